[rtl/core/bmp_stream_to_intensity_core_assert.svh]
// Assertion macros shared by the bitmap intensity decoder modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef BMP_STREAM_TO_INTENSITY_CORE_ASSERT_SVH
`define BMP_STREAM_TO_INTENSITY_CORE_ASSERT_SVH

// Same-cycle implication, idle while reset is high.
`define BSTOI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while reset is high.
`define BSTOI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bstoi_pkg.sv]
// ----------------------------------------------------------------------------
// bstoi_pkg
// Shared types and constants of the bitmap stream to intensity decoder.
// ----------------------------------------------------------------------------
package bstoi_pkg;

  // Default number of bits allowed for image width and height.
  localparam int BSTOI_DIM_BITS = 16;

  // Largest intensity in Q10.8: 765.0.
  localparam logic [17:0] INTENSITY_MAX = 18'd195840;

  // Result request between the parser and the scaling stage.
  typedef struct packed {
    logic [17:0] value;      // colour sum, or sum times alpha when scaled
    logic        scaled;     // 1: value still needs the 256/255 scaling
    logic [15:0] row;
    logic [15:0] column;
    logic        row_end;
    logic        image_end;
    logic        sig_unknown;
    logic        status;
  } bstoi_stage_t;

endpackage

[rtl/core/bstoi_parser.sv]
// ----------------------------------------------------------------------------
// bstoi_parser
// Byte parser: header capture, skip to pixel data, pixel accumulation and the
// alpha multiply, feeding a registered result request to the scaling stage.
// ----------------------------------------------------------------------------
`include "bmp_stream_to_intensity_core_assert.svh"

module bstoi_parser #(
  parameter int DIM_BITS = bstoi_pkg::BSTOI_DIM_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              data_byte,
  input  logic                    file_start,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  output logic                    stage_valid,
  input  logic                    stage_stall,
  output bstoi_pkg::bstoi_stage_t stage
);
  import bstoi_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [4:0] SIG0_POS   = 5'd0;
  localparam logic [4:0] SIG1_POS   = 5'd1;
  localparam logic [4:0] OFS_POS    = 5'd10;
  localparam logic [4:0] WID_POS    = 5'd18;
  localparam logic [4:0] HGT_POS    = 5'd22;
  localparam logic [4:0] BPP_POS    = 5'd28;
  localparam logic [4:0] DECIDE_POS = 5'd29;

  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  localparam logic [1:0] BIP_LAST24 = 2'd2;
  localparam logic [1:0] BIP_LAST32 = 2'd3;

  localparam logic [7:0] CH_A = 8'd65;
  localparam logic [7:0] CH_B = 8'd66;
  localparam logic [7:0] CH_C = 8'd67;
  localparam logic [7:0] CH_I = 8'd73;
  localparam logic [7:0] CH_M = 8'd77;
  localparam logic [7:0] CH_P = 8'd80;
  localparam logic [7:0] CH_T = 8'd84;

  localparam logic [DIM_BITS-1:0] DIM_ONE = {{(DIM_BITS-1){1'b0}}, 1'b1};

  function automatic logic sig_known(input logic [7:0] a, input logic [7:0] b);
    sig_known = (a == CH_B && b == CH_M) || (a == CH_B && b == CH_A) ||
                (a == CH_C && b == CH_I) || (a == CH_C && b == CH_P) ||
                (a == CH_I && b == CH_C) || (a == CH_P && b == CH_T);
  endfunction

  logic [31:0]         byte_position;
  logic [31:0]         pixel_data_offset;
  logic [31:0]         image_width;
  logic [31:0]         image_height;
  logic [15:0]         pixel_depth;
  logic                signature_bad;
  logic [1:0]          parse_phase;
  logic [DIM_BITS-1:0] column_count;
  logic [DIM_BITS-1:0] rows_from_bottom;
  logic [1:0]          byte_in_pixel;
  logic [9:0]          colour_sum;
  logic [1:0]          padding_left;
  logic [7:0]          first_sig_byte;

  // State as seen by this byte: a file start clears everything first.
  logic [31:0]         cur_pos, cur_offset, cur_width, cur_height;
  logic [15:0]         cur_depth;
  logic                cur_sig_bad;
  logic [1:0]          cur_phase;
  logic [DIM_BITS-1:0] cur_col, cur_rfb;
  logic [1:0]          cur_bip, cur_pad;
  logic [9:0]          cur_sum;
  logic [7:0]          cur_first;

  logic [31:0]         byte_position_next, pixel_data_offset_next;
  logic [31:0]         image_width_next, image_height_next;
  logic [15:0]         pixel_depth_next;
  logic                signature_bad_next;
  logic [1:0]          parse_phase_next;
  logic [DIM_BITS-1:0] column_count_next, rows_from_bottom_next;
  logic [1:0]          byte_in_pixel_next, padding_left_next;
  logic [9:0]          colour_sum_next;
  logic [7:0]          first_sig_byte_next;

  logic                accept;
  logic                emit;
  logic                do_pixel;
  logic                pix_done;
  logic                is24;
  logic                rend, iend;
  logic                over, bad_depth;
  logic [9:0]          sum_add;
  logic [17:0]         product;
  logic [DIM_BITS-1:0] width_m1, height_m1, row_d;
  logic [31:0]         row_wide, col_wide;
  logic [4:0]          hdr_pos;
  logic                hdr_low;
  bstoi_stage_t        res;

  assign accept = byte_valid && !byte_stall;
  assign byte_stall = stage_valid && stage_stall;

  always_comb begin
    if (file_start) begin
      cur_pos = '0; cur_offset = '0; cur_width = '0; cur_height = '0;
      cur_depth = '0; cur_sig_bad = 1'b0; cur_phase = PH_HEADER;
      cur_col = '0; cur_rfb = '0; cur_bip = '0; cur_pad = '0;
      cur_sum = '0; cur_first = '0;
    end else begin
      cur_pos = byte_position; cur_offset = pixel_data_offset;
      cur_width = image_width; cur_height = image_height;
      cur_depth = pixel_depth; cur_sig_bad = signature_bad;
      cur_phase = parse_phase; cur_col = column_count; cur_rfb = rows_from_bottom;
      cur_bip = byte_in_pixel; cur_pad = padding_left;
      cur_sum = colour_sum; cur_first = first_sig_byte;
    end
  end

  assign product   = 18'(cur_sum) * 18'(data_byte);
  assign sum_add   = cur_sum + 10'(data_byte);
  assign width_m1  = cur_width[DIM_BITS-1:0] - DIM_ONE;
  assign height_m1 = cur_height[DIM_BITS-1:0] - DIM_ONE;
  assign row_d     = height_m1 - cur_rfb;
  assign row_wide  = 32'(row_d);
  assign col_wide  = 32'(cur_col);
  assign rend      = cur_col == width_m1;
  assign iend      = rend && (cur_rfb == height_m1);
  assign is24      = cur_depth == DEPTH_24;
  assign hdr_pos   = cur_pos[4:0];
  assign hdr_low   = cur_pos[31:5] == 27'd0;
  assign over      = ((cur_width >> DIM_BITS) != 32'd0) ||
                     ((cur_height >> DIM_BITS) != 32'd0);

  always_comb begin
    byte_position_next     = (cur_pos != '1) ? cur_pos + 32'd1 : cur_pos;
    pixel_data_offset_next = cur_offset;
    image_width_next       = cur_width;
    image_height_next      = cur_height;
    pixel_depth_next       = cur_depth;
    signature_bad_next     = cur_sig_bad;
    parse_phase_next       = cur_phase;
    column_count_next      = cur_col;
    rows_from_bottom_next  = cur_rfb;
    byte_in_pixel_next     = cur_bip;
    padding_left_next      = cur_pad;
    colour_sum_next        = cur_sum;
    first_sig_byte_next    = cur_first;
    emit      = 1'b0;
    do_pixel  = 1'b0;
    pix_done  = 1'b0;
    bad_depth = 1'b0;
    res       = '0;

    case (cur_phase)
      PH_HEADER: begin
        if (hdr_low) begin
          case (hdr_pos)
            SIG0_POS:          first_sig_byte_next = data_byte;
            SIG1_POS:          signature_bad_next = !sig_known(cur_first, data_byte);
            OFS_POS:           pixel_data_offset_next[7:0]   = cur_offset[7:0] | data_byte;
            OFS_POS + 5'd1:    pixel_data_offset_next[15:8]  = cur_offset[15:8] | data_byte;
            OFS_POS + 5'd2:    pixel_data_offset_next[23:16] = cur_offset[23:16] | data_byte;
            OFS_POS + 5'd3:    pixel_data_offset_next[31:24] = cur_offset[31:24] | data_byte;
            WID_POS:           image_width_next[7:0]   = cur_width[7:0] | data_byte;
            WID_POS + 5'd1:    image_width_next[15:8]  = cur_width[15:8] | data_byte;
            WID_POS + 5'd2:    image_width_next[23:16] = cur_width[23:16] | data_byte;
            WID_POS + 5'd3:    image_width_next[31:24] = cur_width[31:24] | data_byte;
            HGT_POS:           image_height_next[7:0]   = cur_height[7:0] | data_byte;
            HGT_POS + 5'd1:    image_height_next[15:8]  = cur_height[15:8] | data_byte;
            HGT_POS + 5'd2:    image_height_next[23:16] = cur_height[23:16] | data_byte;
            HGT_POS + 5'd3:    image_height_next[31:24] = cur_height[31:24] | data_byte;
            BPP_POS:           pixel_depth_next[7:0]  = cur_depth[7:0] | data_byte;
            DECIDE_POS:        pixel_depth_next[15:8] = cur_depth[15:8] | data_byte;
            default:           ;
          endcase
          if (hdr_pos == DECIDE_POS) begin
            bad_depth = (pixel_depth_next != DEPTH_24) && (pixel_depth_next != DEPTH_32);
            if (bad_depth || over) begin
              parse_phase_next = PH_DONE;
              emit = 1'b1;
              res.status = 1'b1;
            end else if (cur_width == 32'd0 || cur_height == 32'd0) begin
              parse_phase_next = PH_DONE;
            end else begin
              parse_phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (cur_pos >= cur_offset) begin
          parse_phase_next = PH_PIXELS;
          do_pixel = 1'b1;
        end
      end
      PH_PIXELS: do_pixel = 1'b1;
      default: ;
    endcase

    if (do_pixel) begin
      if (cur_pad != 2'd0) begin
        padding_left_next = cur_pad - 2'd1;
      end else if (is24) begin
        colour_sum_next = sum_add;
        if (cur_bip < BIP_LAST24) begin
          byte_in_pixel_next = cur_bip + 2'd1;
        end else begin
          pix_done = 1'b1;
          res.value = 18'(sum_add);
        end
      end else begin
        if (cur_bip < BIP_LAST32) begin
          colour_sum_next = sum_add;
          byte_in_pixel_next = cur_bip + 2'd1;
        end else begin
          pix_done = 1'b1;
          res.value = product;
          res.scaled = 1'b1;
        end
      end
      if (pix_done) begin
        emit = 1'b1;
        res.row = row_wide[15:0];
        res.column = col_wide[15:0];
        res.row_end = rend;
        res.image_end = iend;
        colour_sum_next = '0;
        byte_in_pixel_next = '0;
        if (iend) begin
          parse_phase_next = PH_DONE;
        end else if (rend) begin
          column_count_next = '0;
          rows_from_bottom_next = cur_rfb + DIM_ONE;
          if (is24) padding_left_next = cur_width[1:0];
        end else begin
          column_count_next = cur_col + DIM_ONE;
        end
      end
    end
    res.sig_unknown = signature_bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      pixel_data_offset <= '0;
      image_width       <= '0;
      image_height      <= '0;
      pixel_depth       <= '0;
      signature_bad     <= 1'b0;
      parse_phase       <= PH_HEADER;
      column_count      <= '0;
      rows_from_bottom  <= '0;
      byte_in_pixel     <= '0;
      colour_sum        <= '0;
      padding_left      <= '0;
      first_sig_byte    <= '0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      pixel_data_offset <= pixel_data_offset_next;
      image_width       <= image_width_next;
      image_height      <= image_height_next;
      pixel_depth       <= pixel_depth_next;
      signature_bad     <= signature_bad_next;
      parse_phase       <= parse_phase_next;
      column_count      <= column_count_next;
      rows_from_bottom  <= rows_from_bottom_next;
      byte_in_pixel     <= byte_in_pixel_next;
      colour_sum        <= colour_sum_next;
      padding_left      <= padding_left_next;
      first_sig_byte    <= first_sig_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!byte_stall) begin
      stage_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      stage <= res;
    end
  end

  `BSTOI_ASSERT_NEXT(a_done_after_last, accept && pix_done && iend, parse_phase == PH_DONE, "parser left the pixel phase open after the last pixel")
  `BSTOI_ASSERT_NEXT(a_pos_monotonic, accept && !file_start, byte_position >= $past(byte_position), "byte position went backward without a file start")
  `BSTOI_ASSERT_NOW(a_pad_only_24, padding_left != 2'd0, parse_phase == PH_PIXELS && pixel_depth == DEPTH_24, "row padding pending outside 24-bit pixel data")

endmodule

[rtl/core/bstoi_scale.sv]
// ----------------------------------------------------------------------------
// bstoi_scale
// Scales alpha-weighted sums by 256/255 with floor rounding, forms the Q10.8
// intensity and holds the result request in the output register.
// ----------------------------------------------------------------------------
`include "bmp_stream_to_intensity_core_assert.svh"

module bstoi_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    stage_valid,
  output logic                    stage_stall,
  input  bstoi_pkg::bstoi_stage_t stage,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [17:0]             intensity_q8,
  output logic [15:0]             display_row,
  output logic [15:0]             display_column,
  output logic                    row_end,
  output logic                    image_end,
  output logic                    signature_unknown,
  output logic                    status
);
  import bstoi_pkg::*;

  localparam logic [17:0] DIVISOR = 18'd255;

  logic [25:0] prod257;
  logic [9:0]  q_est;
  logic [17:0] q255;
  logic [17:0] rem;
  logic        q_fix;
  logic [17:0] rem_left;
  logic [17:0] scaled_value;
  logic [17:0] intensity_next;
  logic        load;

  // floor(x*256/255) = x + floor(x/255). The estimate x*257/65536 is low by at
  // most one, so a single compare on the remainder corrects it.
  assign prod257  = {stage.value, 8'd0} + 26'(stage.value);
  assign q_est    = prod257[25:16];
  assign q255     = {q_est, 8'd0} - 18'(q_est);
  assign rem      = stage.value - q255;
  assign q_fix    = rem >= DIVISOR;
  assign rem_left = q_fix ? rem - DIVISOR : rem;
  assign scaled_value = stage.value + 18'(q_est) + 18'(q_fix);
  assign intensity_next = stage.scaled ? scaled_value : {stage.value[9:0], 8'd0};

  assign stage_stall = result_valid && result_stall;
  assign load = stage_valid && !stage_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!stage_stall) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      intensity_q8      <= intensity_next;
      display_row       <= stage.row;
      display_column    <= stage.column;
      row_end           <= stage.row_end;
      image_end         <= stage.image_end;
      signature_unknown <= stage.sig_unknown;
      status            <= stage.status;
    end
  end

  `BSTOI_ASSERT_NOW(a_rem_range, stage_valid && stage.scaled, rem_left < DIVISOR, "divide by 255 remainder out of range")
  `BSTOI_ASSERT_NOW(a_error_zero, result_valid && status, intensity_q8 == 18'd0 && !row_end, "error result carries pixel data")
  `BSTOI_ASSERT_NOW(a_max_value, result_valid, intensity_q8 <= INTENSITY_MAX && (!image_end || row_end), "intensity above full scale or image end off a row end")

endmodule

[rtl/core/bmp_stream_to_intensity_core.sv]
// ----------------------------------------------------------------------------
// bmp_stream_to_intensity_core
// Byte-serial 24/32-bit bitmap decoder producing per-pixel Q10.8 intensity.
// ----------------------------------------------------------------------------
//   Channel  Handshake                  Payload
//   bytes    byte_valid / byte_stall    data_byte, file_start
//   results  result_valid / result_stall intensity_q8, display_row,
//                                       display_column, row_end, image_end,
//                                       signature_unknown, status
//
// One byte is accepted per cycle while byte_stall is low; the result of the
// byte that completes it passes through the parser register, then the
// divide-by-255 output register. Reset clears the parse state and both valid
// flags. A stalled result holds the output register; byte_stall rises only
// when both the parser register and the output register are full.
// ----------------------------------------------------------------------------
module bmp_stream_to_intensity_core #(
  parameter int DIM_BITS = bstoi_pkg::BSTOI_DIM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [17:0] intensity_q8,
  output logic [15:0] display_row,
  output logic [15:0] display_column,
  output logic        row_end,
  output logic        image_end,
  output logic        signature_unknown,
  output logic        status
);
  import bstoi_pkg::*;

  logic         stage_valid;
  logic         stage_stall;
  bstoi_stage_t stage;

  bstoi_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .file_start (file_start),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .stage_valid(stage_valid),
    .stage_stall(stage_stall),
    .stage      (stage)
  );

  bstoi_scale u_scale (
    .clk              (clk),
    .rst              (rst),
    .stage_valid      (stage_valid),
    .stage_stall      (stage_stall),
    .stage            (stage),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .intensity_q8     (intensity_q8),
    .display_row      (display_row),
    .display_column   (display_column),
    .row_end          (row_end),
    .image_end        (image_end),
    .signature_unknown(signature_unknown),
    .status           (status)
  );

endmodule

[test/bmp_stream_to_intensity_core_tb.sv]
// ----------------------------------------------------------------------------
// bmp_stream_to_intensity_core_tb
// Streams generated bitmap files through the decoder byte by byte and checks
// every pixel or error result against a built-in decoder model. Both channels
// idle at random, and the run also includes a long result hold and a full
// sender pause.
// ----------------------------------------------------------------------------
module bmp_stream_to_intensity_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int ITEM_TARGET    = 1650;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int DIM_BITS       = bstoi_pkg::BSTOI_DIM_BITS;

  // Header layout of the file.
  localparam int POS_SIG_SECOND = 1;
  localparam int POS_OFFSET     = 10;
  localparam int POS_WIDTH      = 18;
  localparam int POS_HEIGHT     = 22;
  localparam int POS_DEPTH      = 28;
  localparam int POS_DECIDE     = 29;
  localparam int HEADER_LEN     = 30;

  localparam logic [15:0] DEPTH_RGB  = 16'd24;
  localparam logic [15:0] DEPTH_RGBA = 16'd32;

  localparam logic ST_PIXEL = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZEROS  = 2;

  typedef enum logic [1:0] {HDR_READ, SKIP_TO_DATA, PIXEL_DATA, PARSE_DONE} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_req_t;

  typedef struct packed {
    logic [17:0] intensity;
    logic [15:0] row;
    logic [15:0] column;
    logic        row_end;
    logic        image_end;
    logic        sig_unknown;
    logic        status;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        file_start = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [17:0] intensity_q8;
  logic [15:0] display_row;
  logic [15:0] display_column;
  logic        row_end;
  logic        image_end;
  logic        signature_unknown;
  logic        status;

  byte_req_t     byte_q[$];
  pixel_result_t expected_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit sender_hold   = 1'b0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  int fail_count     = 0;
  int results_seen   = 0;
  int bytes_accepted = 0;
  int files_queued   = 0;
  int useful_bytes   = 0;

  // Decoder model state.
  logic [31:0]  pos_count;
  logic [31:0]  data_offset;
  logic [31:0]  img_width;
  logic [31:0]  img_height;
  logic [15:0]  bit_depth;
  logic         sig_bad;
  parse_phase_t phase;
  logic [15:0]  col_count;
  logic [15:0]  rows_done;
  logic [1:0]   byte_idx;
  logic [9:0]   rgb_sum;
  logic [1:0]   pad_left;
  logic [7:0]   sig_first;

  bmp_stream_to_intensity_core i_dut (.*);

  always #CLK_HALF clk = ~clk;

  function automatic void clear_decoder();
    pos_count   = '0;
    data_offset = '0;
    img_width   = '0;
    img_height  = '0;
    bit_depth   = '0;
    sig_bad     = 1'b0;
    phase       = HDR_READ;
    col_count   = '0;
    rows_done   = '0;
    byte_idx    = '0;
    rgb_sum     = '0;
    pad_left    = '0;
    sig_first   = '0;
  endfunction

  function automatic bit pixel_step(input logic [7:0] b, output pixel_result_t res);
    logic [31:0] val;
    logic [31:0] row_full;
    res = '0;
    if (pad_left != 0) begin
      pad_left--;
      return 1'b0;
    end
    if (bit_depth == DEPTH_RGB) begin
      rgb_sum += b;
      if (byte_idx < 2'd2) begin
        byte_idx++;
        return 1'b0;
      end
      val = 32'(rgb_sum) << 8;
    end else begin
      // The fourth byte is alpha and scales the colour sum.
      if (byte_idx < 2'd3) begin
        rgb_sum += b;
        byte_idx++;
        return 1'b0;
      end
      val = (32'(rgb_sum) * 32'(b) * 32'd256) / 32'd255;
    end
    row_full        = img_height - 32'd1 - 32'(rows_done);
    res.intensity   = val[17:0];
    res.row         = row_full[15:0];
    res.column      = col_count;
    res.row_end     = (32'(col_count) == img_width - 32'd1);
    res.image_end   = res.row_end && (32'(rows_done) == img_height - 32'd1);
    res.sig_unknown = sig_bad;
    res.status      = ST_PIXEL;
    rgb_sum  = '0;
    byte_idx = '0;
    if (res.image_end) begin
      phase = PARSE_DONE;
    end else if (res.row_end) begin
      col_count = '0;
      rows_done++;
      if (bit_depth == DEPTH_RGB) pad_left = img_width[1:0];
    end else begin
      col_count++;
    end
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                     output pixel_result_t res);
    logic [31:0] pos;
    logic [15:0] pair;
    bit          emit;
    bit          oversize;
    emit = 1'b0;
    res  = '0;
    if (fs) clear_decoder();
    pos = pos_count;
    case (phase)
      HDR_READ: begin
        pair = {sig_first, b};
        if (pos == 0) sig_first = b;
        if (pos == POS_SIG_SECOND) begin
          sig_bad = !(pair == "BM" || pair == "BA" || pair == "CI" ||
                      pair == "CP" || pair == "IC" || pair == "PT");
        end
        if (pos >= POS_OFFSET && pos < POS_OFFSET + 4)
          data_offset |= 32'(b) << (8 * (pos - POS_OFFSET));
        if (pos >= POS_WIDTH && pos < POS_WIDTH + 4)
          img_width |= 32'(b) << (8 * (pos - POS_WIDTH));
        if (pos >= POS_HEIGHT && pos < POS_HEIGHT + 4)
          img_height |= 32'(b) << (8 * (pos - POS_HEIGHT));
        if (pos >= POS_DEPTH && pos < POS_DEPTH + 2)
          bit_depth |= 16'(b) << (8 * (pos - POS_DEPTH));
        if (pos == POS_DECIDE) begin
          oversize = ((img_width >> DIM_BITS) != 0) || ((img_height >> DIM_BITS) != 0);
          if ((bit_depth != DEPTH_RGB && bit_depth != DEPTH_RGBA) || oversize) begin
            phase           = PARSE_DONE;
            res.sig_unknown = sig_bad;
            res.status      = ST_ERROR;
            emit            = 1'b1;
          end else if (img_width == 0 || img_height == 0) begin
            phase = PARSE_DONE;
          end else begin
            phase = SKIP_TO_DATA;
          end
        end
      end
      SKIP_TO_DATA: begin
        if (pos >= data_offset) begin
          phase = PIXEL_DATA;
          emit  = pixel_step(b, res);
        end
      end
      PIXEL_DATA: emit = pixel_step(b, res);
      default: ;
    endcase
    if (pos_count != '1) pos_count++;
    return emit;
  endfunction

  // Sender: a request stays on the bus unchanged until it is accepted.
  always @(posedge clk) begin : driver
    byte_req_t req;
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      if (byte_q.size() != 0 && !sender_hold && $urandom_range(99, 0) >= send_idle_pct) begin
        req = byte_q.pop_front();
        byte_valid <= 1'b1;
        data_byte  <= req.data;
        file_start <= req.start;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : predictor
    pixel_result_t res;
    if (rst) begin
      clear_decoder();
    end else if (byte_valid && !byte_stall) begin
      bytes_accepted++;
      if (decode_byte(data_byte, file_start, res)) expected_q.push_back(res);
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual intensity %0d row %0d col %0d",
                 $time, intensity_q8, display_row, display_column);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("intensity_q8", 32'(want.intensity), 32'(intensity_q8));
        check_field("display_row", 32'(want.row), 32'(display_row));
        check_field("display_column", 32'(want.column), 32'(display_column));
        check_field("row_end", 32'(want.row_end), 32'(row_end));
        check_field("image_end", 32'(want.image_end), 32'(image_end));
        check_field("signature_unknown", 32'(want.sig_unknown), 32'(signature_unknown));
        check_field("status", 32'(want.status), 32'(status));
      end
    end
  end

  // Counts only the cycles in which work is pending but nothing moves.
  always @(posedge clk) begin : watchdog
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (byte_q.size() == 0 && !byte_valid && expected_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_byte(input int fill);
    int r;
    r = $urandom_range(7, 0);
    case (fill)
      FILL_ONES:  return 8'hFF;
      FILL_ZEROS: return 8'h00;
      default:    return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic s);
    byte_req_t req;
    req.data  = d;
    req.start = s;
    byte_q.push_back(req);
  endtask

  // Queues one file: header, then up to body_cap bytes of offset gap and
  // pixel data (all of it when body_cap is negative), then ignored trailer.
  task automatic queue_image(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] width, input logic [31:0] height,
                             input logic [15:0] depth, input int fill,
                             input int body_cap, input int junk);
    logic [7:0] hdr [HEADER_LEN];
    longint     bpp, pad, filler, body_len;
    bit         decodable;
    for (int i = 0; i < HEADER_LEN; i++) hdr[i] = rand_byte(FILL_RANDOM);
    hdr[0] = sig[15:8];
    hdr[1] = sig[7:0];
    for (int i = 0; i < 4; i++) begin
      hdr[POS_OFFSET + i] = offset[8*i +: 8];
      hdr[POS_WIDTH + i]  = width[8*i +: 8];
      hdr[POS_HEIGHT + i] = height[8*i +: 8];
    end
    hdr[POS_DEPTH]     = depth[7:0];
    hdr[POS_DEPTH + 1] = depth[15:8];
    decodable = (depth == DEPTH_RGB || depth == DEPTH_RGBA) && width != 0 && height != 0 &&
                (width >> DIM_BITS) == 0 && (height >> DIM_BITS) == 0;
    bpp    = (depth == DEPTH_RGB) ? 3 : 4;
    pad    = (depth == DEPTH_RGB) ? longint'(width % 4) : 0;
    filler = (offset > HEADER_LEN) ? longint'(offset) - HEADER_LEN : 0;
    body_len = decodable ?
               filler + longint'(height) * (longint'(width) * bpp + pad) - pad : 0;
    if (body_cap >= 0 && body_len > body_cap) body_len = body_cap;
    for (int i = 0; i < HEADER_LEN; i++) push_byte(hdr[i], i == 0);
    for (longint k = 0; k < body_len; k++) push_byte(rand_byte(fill), 1'b0);
    for (int k = 0; k < junk; k++) push_byte(rand_byte(FILL_RANDOM), 1'b0);
    useful_bytes += HEADER_LEN + int'(body_len);
    files_queued++;
  endtask

  task automatic queue_random_file();
    int          pick, n;
    logic [15:0] sig, depth;
    logic [31:0] w, h, offset;
    pick = $urandom_range(99, 0);
    if ($urandom_range(99, 0) < 85) begin
      case ($urandom_range(5, 0))
        0: sig = "BM";
        1: sig = "BA";
        2: sig = "CI";
        3: sig = "CP";
        4: sig = "IC";
        default: sig = "PT";
      endcase
    end else begin
      sig = 16'($urandom);
    end
    depth = $urandom_range(1, 0) ? DEPTH_RGB : DEPTH_RGBA;
    w = $urandom_range(6, 1);
    h = $urandom_range(4, 1);
    case ($urandom_range(3, 0))
      0, 1: offset = 54;
      2: offset = $urandom_range(40, 0);
      default: offset = $urandom_range(90, 30);
    endcase
    if (pick < 70) begin
      queue_image(sig, offset, w, h, depth, FILL_RANDOM, -1, $urandom_range(3, 0));
    end else if (pick < 78) begin
      // Large images are cut short by the next file.
      w = $urandom_range(1, 0) ? 32'hFFFF : 32'($urandom_range(65535, 1));
      h = $urandom_range(1, 0) ? 32'hFFFF : 32'($urandom_range(65535, 1));
      queue_image(sig, offset, w, h, depth, FILL_RANDOM, $urandom_range(60, 0), 0);
    end else if (pick < 86) begin
      case ($urandom_range(3, 0))
        0: depth = 16'($urandom);
        1: depth = {8'($urandom_range(255, 1)), depth[7:0]};
        2: w = $urandom | 32'h0001_0000;
        default: h = 32'hFFFF_FFFF - $urandom_range(15, 0);
      endcase
      queue_image(sig, offset, w, h, depth, FILL_RANDOM, 0, $urandom_range(6, 0));
    end else if (pick < 90) begin
      if ($urandom_range(1, 0)) w = 0;
      else h = 0;
      queue_image(sig, offset, w, h, depth, FILL_RANDOM, 0, $urandom_range(6, 0));
    end else if (pick < 94) begin
      queue_image(sig, offset, w, h, depth, FILL_RANDOM, $urandom_range(30, 0), 0);
    end else begin
      // Raw noise, now and then restarting the parse at a random point.
      n = $urandom_range(40, 5);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), $urandom_range(31, 0) == 0);
      useful_bytes += n;
    end
  endtask

  task automatic queue_random_until(input int target);
    while (useful_bytes < target) queue_random_file();
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_valid || expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int half;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 87;
    queue_image("BM", 54, 3, 2, DEPTH_RGB, FILL_ONES, -1, 0);
    queue_image("BA", 0, 2, 2, DEPTH_RGBA, FILL_ONES, -1, 0);
    queue_image("CI", 30, 4, 1, DEPTH_RGB, FILL_ZEROS, -1, 2);
    queue_image("CP", 26, 1, 3, DEPTH_RGBA, FILL_RANDOM, -1, 0);
    queue_image("IC", 40, 2, 3, DEPTH_RGB, FILL_RANDOM, -1, 4);
    queue_image("PT", 54, 1, 2, DEPTH_RGB, FILL_RANDOM, -1, 0);
    queue_image("QZ", 0, 1, 1, DEPTH_RGB, FILL_RANDOM, -1, 0);
    queue_image("BM", 54, 2, 2, 16'd16, FILL_RANDOM, 0, 3);
    queue_image("BM", 54, 2, 2, 16'h0118, FILL_RANDOM, 0, 3);
    queue_image("BM", 54, 32'h0001_0000, 1, DEPTH_RGB, FILL_RANDOM, 0, 2);
    queue_image("BM", 54, 1, 32'hFFFF_FFFF, DEPTH_RGBA, FILL_RANDOM, 0, 2);
    queue_image("BM", 54, 0, 3, DEPTH_RGB, FILL_RANDOM, 0, 4);
    queue_image("BM", 54, 3, 0, DEPTH_RGBA, FILL_RANDOM, 0, 4);
    queue_image("BM", 0, 32'hFFFF, 32'hFFFF, DEPTH_RGBA, FILL_RANDOM, 16, 0);
    queue_image("BM", 32'h8000_0000, 2, 2, DEPTH_RGB, FILL_RANDOM, 10, 0);
    // A header cut off partway, then a fresh file with one padding byte per row.
    for (int i = 0; i < 12; i++) push_byte(rand_byte(FILL_RANDOM), i == 0);
    useful_bytes += 12;
    queue_image("PT", 0, 5, 2, DEPTH_RGB, FILL_RANDOM, -1, 0);
    wait_drained();

    // The long result hold lets the block fill up while bytes keep coming.
    hold_req++;
    queue_random_until(650);
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 35;
    queue_random_until(1150);
    half = byte_q.size() / 2;
    while (byte_q.size() > half) @(negedge clk);
    sender_hold = 1'b1;
    while (byte_valid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sender_hold = 1'b0;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_until(ITEM_TARGET);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Decoded %0d files from %0d accepted bytes and checked %0d results.",
             files_queued, bytes_accepted, results_seen);
    $display("Idling mixes: sender-light, receiver-light, none; plus a long hold and a pause.");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, expected_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
